// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the reuse-distance tag store.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds on that edge.
`define SCRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons holds on the next edge.
`define SCRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/scrd_pkg.sv -----
// Shared types and constants for the sampled reuse-distance tag store.
// No dependencies; used by every module of the block.
`default_nettype none

package scrd_pkg;

  localparam int SET_W        = 9;
  localparam int SUB_W        = 5;
  localparam int TAG_W        = 10;
  localparam int STAMP_W      = 8;
  localparam int ADDR_IN_W    = 14;
  localparam int NUM_SETS     = 512;
  localparam int NUM_SUBS     = 32;
  localparam int WAYS_DEFAULT = 8;

  // Request fields: mode 0 = lookup, 1 = insert
  typedef struct packed {
    logic                 mode;
    logic [ADDR_IN_W-1:0] blk_addr;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [STAMP_W-1:0] reuse_gap;
  } out_t;

  // One way of one set as held in the tag memory
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ----- rtl/scrd_ram.sv -----
// Single-port tag memory with registered read data, read-before-write.
// Generic; entry layout comes from scrd_pkg at the top level.
`default_nettype none

module scrd_ram #(
  parameter int DEPTH = scrd_pkg::NUM_SETS * scrd_pkg::WAYS_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = scrd_pkg::ENTRY_W
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write on request, always register the addressed word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/sampled_cache_reuse_distance.sv -----
// Top level of the sampled reuse-distance tag store: sequencer, sub-cache clocks.
// Depends on scrd_pkg, scrd_ram and assert_macros.svh.
`default_nettype none

// Sampled reuse-distance tag store. A request is taken when start is high and
// busy is low; busy then stays high until the result is presented. The result
// shows on out_data for exactly one cycle with out_valid high, and the receiver
// cannot stall it. One comparator walks the ways of the addressed set, each way
// with a read of the single-port tag memory, then a compare. A lookup stops at
// the first match, or the last way on a miss; an insert stops at the first free
// way, or the last way when all ways are valid, and then writes back. The result
// appears on the cycle after the final state, and busy is already low then.
// After reset the block clears the valid bits of all 512*WAYS entries with one
// memory write per cycle, holding busy high meanwhile.

`include "assert_macros.svh"

module sampled_cache_reuse_distance #(
  parameter int WAYS = scrd_pkg::WAYS_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire scrd_pkg::in_t  in_data,
  output logic              out_valid,
  output scrd_pkg::out_t    out_data
);

  localparam int DEPTH  = scrd_pkg::NUM_SETS * WAYS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [ADDR_W-1:0]             clr_r, clr_nxt;
  logic                          mode_r;
  logic [scrd_pkg::TAG_W-1:0]    tag_r;
  logic [scrd_pkg::SET_W-1:0]    set_r;
  logic [scrd_pkg::SUB_W-1:0]    sub_r;
  logic [WAY_W-1:0]              way_r, way_nxt;
  logic [WAY_W-1:0]              victim_r, victim_nxt;
  logic [scrd_pkg::STAMP_W-1:0]  min_r, min_nxt;
  logic [scrd_pkg::STAMP_W-1:0]  time_r [scrd_pkg::NUM_SUBS];
  logic                          out_valid_r, out_valid_nxt;
  scrd_pkg::out_t                out_r, out_nxt;

  logic [ADDR_W-1:0]             row_base;
  logic [ADDR_W-1:0]             ram_addr;
  logic                          ram_we;
  scrd_pkg::entry_t              ram_wdata;
  scrd_pkg::entry_t              ram_rdata;
  logic [scrd_pkg::STAMP_W-1:0]  cur_time;
  logic [scrd_pkg::STAMP_W-1:0]  new_time;
  logic                          last_way;
  logic                          accept;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign row_base = ADDR_W'(set_r) * ADDR_W'(WAYS);
  assign cur_time = time_r[sub_r];
  assign new_time = cur_time + scrd_pkg::STAMP_W'(1);
  assign last_way = (way_r == WAY_W'(WAYS - 1));

  // Memory port: clear sweep, write-back of the victim, or read of the current way
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = row_base + ADDR_W'(way_r);
    ram_wdata = '0;
    if (state_r == S_CLR) begin
      ram_we   = 1'b1;
      ram_addr = clr_r;
    end else if (state_r == S_WR) begin
      ram_we          = 1'b1;
      ram_addr        = row_base + ADDR_W'(victim_r);
      ram_wdata.valid = 1'b1;
      ram_wdata.tag   = tag_r;
      ram_wdata.stamp = new_time;
    end
  end

  scrd_ram #(
    .DEPTH (DEPTH),
    .AW    (ADDR_W),
    .DW    (scrd_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencer: clear sweep after reset, then walk the ways, compare one per visit, finish with a result
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    way_nxt       = way_r;
    victim_nxt    = victim_r;
    min_nxt       = min_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          way_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        if (!mode_r) begin
          // Lookup: stop at the first valid matching way
          if (ram_rdata.valid && (ram_rdata.tag == tag_r)) begin
            out_valid_nxt     = 1'b1;
            out_nxt.hit       = 1'b1;
            out_nxt.reuse_gap = cur_time - ram_rdata.stamp;
            state_nxt         = S_IDLE;
          end else if (last_way) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            state_nxt     = S_IDLE;
          end else begin
            way_nxt   = way_r + WAY_W'(1);
            state_nxt = S_RD;
          end
        end else begin
          // Insert: take the first free way, else track the smallest stamp
          if (!ram_rdata.valid) begin
            victim_nxt = way_r;
            state_nxt  = S_WR;
          end else begin
            if ((way_r == '0) || (ram_rdata.stamp < min_r)) begin
              min_nxt    = ram_rdata.stamp;
              victim_nxt = way_r;
            end
            if (last_way) begin
              state_nxt = S_WR;
            end else begin
              way_nxt   = way_r + WAY_W'(1);
              state_nxt = S_RD;
            end
          end
        end
      end
      S_WR: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    way_r    <= way_nxt;
    victim_r <= victim_nxt;
    min_r    <= min_nxt;
    out_r    <= out_nxt;
    if (accept) begin
      mode_r <= in_data.mode;
      tag_r  <= in_data.blk_addr[13:4];
      set_r  <= in_data.blk_addr[8:0];
      sub_r  <= in_data.blk_addr[8:4];
    end
  end

  // Sub-cache clocks: advance on insert write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < scrd_pkg::NUM_SUBS; i++) begin
        time_r[i] <= '0;
      end
    end else if (state_r == S_WR) begin
      time_r[sub_r] <= new_time;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SCRD_ASSERT_NOW(a_result_frees_block, out_valid, !busy)
  `SCRD_ASSERT_NEXT(a_request_sets_busy, start && !busy, busy)
  `SCRD_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `SCRD_ASSERT_NOW(a_miss_zero_dist, out_valid && !out_data.hit, out_data.reuse_gap == '0)

endmodule

`default_nettype wire
